### src/lbo_pkg.sv
// ----------------------------------------------------------------------------
// lbo_pkg: shared types and constants of the label boundary overlay
// Frame geometry limits, field widths, register indexes and the
// control structs that pass between the blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package lbo_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
	localparam int LABEL_BITS   = 16;
	localparam int COLOUR_BITS  = 24;
	localparam int WIDTH_BITS   = 12;
	localparam int HEIGHT_BITS  = 13;
	localparam int ROW_BITS     = 12;
	localparam int HEIGHT_LIMIT = 4096;

	localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
	localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);
	localparam logic [7:0]             WHITE        = 8'd255;

	// Register indexes, taken from paddr[2].
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [WIDTH_BITS-1:0]  width;    // saturated to 1..MAX_WIDTH
		logic [HEIGHT_BITS-1:0] height;   // saturated to 1..HEIGHT_LIMIT
		logic                   restart;  // a register write restarts the frame
	} cfg_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] column;
		logic                 emit_above;
		logic                 interior;
		logic                 emit_self;
		logic                 last_col;
	} pos_t;

endpackage

`default_nettype wire

### src/lbo_cfg.sv
// ----------------------------------------------------------------------------
// lbo_cfg: configuration registers
// APB write and read of image width and height, with saturated copies
// for the datapath and a restart strobe on every write.
// ----------------------------------------------------------------------------
`default_nettype none

module lbo_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output lbo_pkg::cfg_t           cfg
);

	logic [lbo_pkg::WIDTH_BITS-1:0]  width_q;
	logic [lbo_pkg::HEIGHT_BITS-1:0] height_q;
	logic                            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbo_pkg::WIDTH_RESET;
			height_q <= lbo_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			if (paddr[2] == lbo_pkg::REG_WIDTH) begin
				width_q <= pwdata[lbo_pkg::WIDTH_BITS-1:0];
			end else begin
				height_q <= pwdata[lbo_pkg::HEIGHT_BITS-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == lbo_pkg::REG_HEIGHT) begin
			prdata = 32'(height_q);
		end else begin
			prdata = 32'(width_q);
		end
	end

	always_comb begin
		cfg.restart = wr_en;
		if (width_q == '0) begin
			cfg.width = lbo_pkg::WIDTH_BITS'(1);
		end else if (width_q > lbo_pkg::WIDTH_BITS'(lbo_pkg::MAX_WIDTH)) begin
			cfg.width = lbo_pkg::WIDTH_BITS'(lbo_pkg::MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = lbo_pkg::HEIGHT_BITS'(1);
		end else if (height_q > lbo_pkg::HEIGHT_BITS'(lbo_pkg::HEIGHT_LIMIT)) begin
			cfg.height = lbo_pkg::HEIGHT_BITS'(lbo_pkg::HEIGHT_LIMIT);
		end else begin
			cfg.height = height_q;
		end
	end

endmodule

`default_nettype wire

### src/lbo_raster.sv
// ----------------------------------------------------------------------------
// lbo_raster: raster position counters
// Tracks column and row of the next pixel and derives the per-pixel
// flags: which results it causes and whether the pixel above is interior.
// ----------------------------------------------------------------------------
`default_nettype none

module lbo_raster (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lbo_pkg::cfg_t cfg,
	input  wire logic     advance,
	output lbo_pkg::pos_t pos
);

	logic [lbo_pkg::ADDR_BITS-1:0] col_q;
	logic [lbo_pkg::ROW_BITS-1:0]  row_q;
	logic                          last_row;
	logic                          last_col;
	logic                          col_interior;

	assign last_col = (lbo_pkg::WIDTH_BITS'(col_q) + lbo_pkg::WIDTH_BITS'(1)) == cfg.width;
	assign last_row = (lbo_pkg::HEIGHT_BITS'(row_q) + lbo_pkg::HEIGHT_BITS'(1)) == cfg.height;
	// The pixel above must be off the frame edge, so that its right neighbor is inside.
	assign col_interior = (col_q != '0) &&
		((lbo_pkg::WIDTH_BITS'(col_q) + lbo_pkg::WIDTH_BITS'(2)) <= cfg.width);

	always_comb begin
		pos.column     = col_q;
		pos.emit_above = (row_q != '0);
		pos.interior   = (row_q > lbo_pkg::ROW_BITS'(1)) && col_interior;
		pos.emit_self  = last_row;
		pos.last_col   = last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + lbo_pkg::ROW_BITS'(1);
			end else begin
				col_q <= col_q + lbo_pkg::ADDR_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/lbo_line_store.sv
// ----------------------------------------------------------------------------
// lbo_line_store: one-row line buffer
// Holds label and colour of the previous row. Reads the entry above the
// incoming pixel and its right neighbor, then overwrites the entry above.
// ----------------------------------------------------------------------------
`default_nettype none

module lbo_line_store (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [lbo_pkg::ADDR_BITS-1:0]       addr,
	input  wire logic [lbo_pkg::LABEL_BITS-1:0]      wr_label,
	input  wire logic [lbo_pkg::COLOUR_BITS-1:0]     wr_colour,
	output logic      [lbo_pkg::LABEL_BITS-1:0]      above_label,
	output logic      [lbo_pkg::COLOUR_BITS-1:0]     above_colour,
	output logic      [lbo_pkg::LABEL_BITS-1:0]      right_label
);

	localparam int WORD_BITS = lbo_pkg::LABEL_BITS + lbo_pkg::COLOUR_BITS;

	logic [WORD_BITS-1:0]          mem [lbo_pkg::MAX_WIDTH];
	logic [lbo_pkg::ADDR_BITS-1:0] addr_right;

	// The last column has no right neighbor in the row; that read is never used.
	assign addr_right = addr + lbo_pkg::ADDR_BITS'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			{above_label, above_colour} <= mem[addr];
			right_label                 <= mem[addr_right][WORD_BITS-1 -: lbo_pkg::LABEL_BITS];
			mem[addr]                   <= {wr_label, wr_colour};
		end
	end

endmodule

`default_nettype wire

### src/lbo_overlay.sv
// ----------------------------------------------------------------------------
// lbo_overlay: boundary test and result sequencing
// One stage register holds the accepted pixel, beside the line store read
// data; up to two results leave it through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbo_overlay (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            pix_valid,
	output logic                                 pix_stall,
	output logic                                 accept,
	input  wire lbo_pkg::pos_t                   pos,
	input  wire logic [lbo_pkg::LABEL_BITS-1:0]  label,
	input  wire logic [lbo_pkg::COLOUR_BITS-1:0] colour,
	input  wire logic [lbo_pkg::LABEL_BITS-1:0]  above_label,
	input  wire logic [lbo_pkg::COLOUR_BITS-1:0] above_colour,
	input  wire logic [lbo_pkg::LABEL_BITS-1:0]  right_label,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic [7:0]                           out_blue,
	output logic [7:0]                           out_green,
	output logic [7:0]                           out_red,
	output logic                                 boundary,
	output logic                                 frame_end
);

	localparam int WHITE3 = 3;

	logic                            valid_s1;
	logic                            pend_above_s1;
	logic                            pend_self_s1;
	logic                            interior_s1;
	logic                            last_col_s1;
	logic [lbo_pkg::LABEL_BITS-1:0]  label_s1;
	logic [lbo_pkg::COLOUR_BITS-1:0] colour_s1;

	logic                            res_valid_q;
	logic [lbo_pkg::COLOUR_BITS-1:0] res_colour_q;
	logic                            res_bnd_q;
	logic                            res_fend_q;

	logic out_free;
	logic load;
	logic take_above;
	logic done;
	logic bnd;

	assign out_free   = !res_valid_q || !res_stall;
	assign load       = valid_s1 && (pend_above_s1 || pend_self_s1) && out_free;
	assign take_above = load && pend_above_s1;
	// The stage empties when its last pending result moves out, or if it has none.
	assign done = valid_s1 && !(pend_above_s1 && pend_self_s1) &&
		(!(pend_above_s1 || pend_self_s1) || out_free);
	assign accept    = pix_valid && (!valid_s1 || done);
	assign pix_stall = valid_s1 && !done;

	assign bnd = interior_s1 && ((above_label != label_s1) || (above_label != right_label));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			pend_above_s1 <= 1'b0;
			pend_self_s1  <= 1'b0;
		end else if (accept) begin
			valid_s1      <= 1'b1;
			pend_above_s1 <= pos.emit_above;
			pend_self_s1  <= pos.emit_self;
		end else if (done) begin
			valid_s1      <= 1'b0;
			pend_above_s1 <= 1'b0;
			pend_self_s1  <= 1'b0;
		end else if (take_above) begin
			pend_above_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			interior_s1 <= pos.interior;
			last_col_s1 <= pos.last_col;
			label_s1    <= label;
			colour_s1   <= colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (take_above) begin
				res_colour_q <= bnd ? {WHITE3{lbo_pkg::WHITE}} : above_colour;
				res_bnd_q    <= bnd;
				res_fend_q   <= 1'b0;
			end else begin
				res_colour_q <= colour_s1;
				res_bnd_q    <= 1'b0;
				res_fend_q   <= last_col_s1;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign out_blue  = res_colour_q[7:0];
	assign out_green = res_colour_q[15:8];
	assign out_red   = res_colour_q[23:16];
	assign boundary  = res_bnd_q;
	assign frame_end = res_fend_q;

	a_bnd_white: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_bnd_q |-> res_colour_q == {WHITE3{lbo_pkg::WHITE}})
		else $error("boundary result not painted white");

	a_fend_not_bnd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_fend_q |-> !res_bnd_q)
		else $error("frame end marked on a boundary result");

	a_above_first: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.emit_above |=> valid_s1 && pend_above_s1)
		else $error("pixel above not queued after accept");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !pend_above_s1 && !pend_self_s1)
		else $error("pending result in an empty stage");

endmodule

`default_nettype wire

### src/label_boundary_overlay.sv
// ----------------------------------------------------------------------------
// label_boundary_overlay: segment boundary overlay on a pixel stream
// Paints interior pixels white where the segment label changes toward the pixel
// below or to the right; output runs one row behind the input.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  pixel     in         pix_valid / pix_stall  label, blue, green, red
//  result    out        res_valid / res_stall  out_blue, out_green, out_red,
//                                              boundary, frame_end
//  config    in         APB psel/penable       image_width (0x0), image_height (0x4)
//
// One pixel per cycle, while results are not stalled, in every row but the last;
// a last-row pixel yields two results (one in a single-row frame), so there the
// next pixel is taken only as the second result enters the output register.
// Each result passes through the stage register and then the output register.
// Reset clears counters and handshake state; the line store needs no clearing,
// since every read follows a write of the same entry in the row before.
// A stalled result holds the output register and, once the stage behind it
// is full, stalls the pixel input.
`default_nettype none

module label_boundary_overlay (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        pix_valid,
	output logic             pix_stall,
	input  wire logic [15:0] label,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  red,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       out_blue,
	output logic [7:0]       out_green,
	output logic [7:0]       out_red,
	output logic             boundary,
	output logic             frame_end
);

	lbo_pkg::cfg_t                   cfg;
	lbo_pkg::pos_t                   pos;
	logic                            accept;
	logic [lbo_pkg::LABEL_BITS-1:0]  lab;
	logic [lbo_pkg::COLOUR_BITS-1:0] colour;
	logic [lbo_pkg::LABEL_BITS-1:0]  above_label;
	logic [lbo_pkg::COLOUR_BITS-1:0] above_colour;
	logic [lbo_pkg::LABEL_BITS-1:0]  right_label;

	assign lab    = label[lbo_pkg::LABEL_BITS-1:0];
	assign colour = {red, green, blue};

	lbo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lbo_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept),
		.pos     (pos)
	);

	lbo_line_store u_line (
		.clk          (clk),
		.en           (accept),
		.addr         (pos.column),
		.wr_label     (lab),
		.wr_colour    (colour),
		.above_label  (above_label),
		.above_colour (above_colour),
		.right_label  (right_label)
	);

	lbo_overlay u_overlay (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_stall    (pix_stall),
		.accept       (accept),
		.pos          (pos),
		.label        (lab),
		.colour       (colour),
		.above_label  (above_label),
		.above_colour (above_colour),
		.right_label  (right_label),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_blue     (out_blue),
		.out_green    (out_green),
		.out_red      (out_red),
		.boundary     (boundary),
		.frame_end    (frame_end)
	);

endmodule

`default_nettype wire

### test/label_boundary_overlay_test.sv
// ----------------------------------------------------------------------------
// label_boundary_overlay_test: self-checking bench for the boundary overlay
// Streams labelled pixel frames of many geometries through the block and
// predicts every output pixel from a line-buffer model of its own. Both
// channels idle in random bursts, and geometry changes go through the APB port.
// ----------------------------------------------------------------------------
module label_boundary_overlay_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       boundary;
		logic       frame_end;
	} overlay_pixel_t;

	class overlay_scoreboard;
		logic [lbo_pkg::WIDTH_BITS-1:0]  width_reg;
		logic [lbo_pkg::HEIGHT_BITS-1:0] height_reg;
		logic [lbo_pkg::LABEL_BITS-1:0]  label_row [lbo_pkg::MAX_WIDTH];
		logic [lbo_pkg::COLOUR_BITS-1:0] colour_row [lbo_pkg::MAX_WIDTH];
		int unsigned                     column;
		int unsigned                     row;
		int unsigned                     checked;
		int                              mismatches;
		overlay_pixel_t                  expected_q [$];

		function new();
			width_reg  = lbo_pkg::WIDTH_RESET;
			height_reg = lbo_pkg::HEIGHT_RESET;
			column     = 0;
			row        = 0;
			checked    = 0;
			mismatches = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Any register write restarts the frame; the line store is kept.
		function void set_reg(logic idx, logic [31:0] value);
			if (idx == lbo_pkg::REG_WIDTH) begin
				width_reg = value[lbo_pkg::WIDTH_BITS-1:0];
			end else begin
				height_reg = value[lbo_pkg::HEIGHT_BITS-1:0];
			end
			column = 0;
			row    = 0;
		endfunction

		function void queue_pixel(logic [lbo_pkg::COLOUR_BITS-1:0] colour, bit on_edge,
				bit last);
			overlay_pixel_t px;
			px.blue      = on_edge ? lbo_pkg::WHITE : colour[7:0];
			px.green     = on_edge ? lbo_pkg::WHITE : colour[15:8];
			px.red       = on_edge ? lbo_pkg::WHITE : colour[23:16];
			px.boundary  = on_edge;
			px.frame_end = last;
			expected_q   = {expected_q, px};
		endfunction

		function void take_pixel(logic [lbo_pkg::LABEL_BITS-1:0] lab, logic [7:0] b,
				logic [7:0] g, logic [7:0] r);
			int unsigned                     w;
			int unsigned                     h;
			logic [lbo_pkg::COLOUR_BITS-1:0] colour;
			bit                              last_row;
			bit                              last_col;
			bit                              on_edge;
			w = (width_reg == 0) ? 1 :
				(width_reg > lbo_pkg::MAX_WIDTH) ? lbo_pkg::MAX_WIDTH : width_reg;
			h = (height_reg == 0) ? 1 :
				(height_reg > lbo_pkg::HEIGHT_LIMIT) ? lbo_pkg::HEIGHT_LIMIT : height_reg;
			colour   = {r, g, b};
			last_row = (row + 1 == h);
			last_col = (column + 1 == w);
			if (row >= 1) begin
				// The pixel above is inside the frame border only when it is not in
				// row zero and not in the first or last column.
				on_edge = 1'b0;
				if (row >= 2 && column >= 1 && column + 2 <= w) begin
					on_edge = (label_row[column] != lab) ||
						(label_row[column] != label_row[column + 1]);
				end
				queue_pixel(colour_row[column], on_edge, 1'b0);
			end
			label_row[column]  = lab;
			colour_row[column] = colour;
			if (last_row) begin
				queue_pixel(colour, 1'b0, last_col);
			end
			if (last_col) begin
				column = 0;
				row    = last_row ? 0 : row + 1;
			end else begin
				column = column + 1;
			end
		endfunction

		task check_pixel(overlay_pixel_t got);
			overlay_pixel_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("output beat %0d arrived with nothing expected", checked));
			end else begin
				want = expected_q.pop_front();
				if (got.blue !== want.blue)
					report($sformatf("beat %0d out_blue %0d, expected %0d", checked,
						got.blue, want.blue));
				if (got.green !== want.green)
					report($sformatf("beat %0d out_green %0d, expected %0d", checked,
						got.green, want.green));
				if (got.red !== want.red)
					report($sformatf("beat %0d out_red %0d, expected %0d", checked,
						got.red, want.red));
				if (got.boundary !== want.boundary)
					report($sformatf("beat %0d boundary %b, expected %b", checked,
						got.boundary, want.boundary));
				if (got.frame_end !== want.frame_end)
					report($sformatf("beat %0d frame_end %b, expected %b", checked,
						got.frame_end, want.frame_end));
			end
			checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        pix_valid;
	logic        pix_stall;
	logic [15:0] label;
	logic [7:0]  blue;
	logic [7:0]  green;
	logic [7:0]  red;
	logic        res_valid;
	logic        res_stall;
	logic [7:0]  out_blue;
	logic [7:0]  out_green;
	logic [7:0]  out_red;
	logic        boundary;
	logic        frame_end;

	overlay_scoreboard sb = new();
	bit                idling = 1'b1;
	int unsigned       hold_requests = 0;
	int unsigned       holds_served = 0;
	int unsigned       pixels_sent = 0;

	label_boundary_overlay u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.label     (label),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_blue  (out_blue),
		.out_green (out_green),
		.out_red   (out_red),
		.boundary  (boundary),
		.frame_end (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// Result side: random stall bursts, plus long holds on request so that the
	// block backs up and stalls its pixel input.
	initial begin
		int unsigned burst;
		burst = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				burst = 400;
			end
			if (burst > 0) begin
				burst--;
				res_stall <= 1'b1;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(0, 16);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		overlay_pixel_t got;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				got = {out_blue, out_green, out_red, boundary, frame_end};
				sb.check_pixel(got);
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	// Leaves valid high so that the next beat can follow back to back; callers
	// lower it once a run of beats is over.
	task automatic send_pixel(input logic [15:0] lab, input logic [7:0] b,
			input logic [7:0] g, input logic [7:0] r);
		if (idling && $urandom_range(0, 7) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		label     <= lab;
		blue      <= b;
		green     <= g;
		red       <= r;
		do @(posedge clk); while (pix_stall);
		sb.take_pixel(lab, b, g, r);
		pixels_sent++;
	endtask

	// Labels form diagonal bands of random size around a random base, with an
	// optional share of fully random labels as noise.
	task automatic send_pixels(input int unsigned w, input int unsigned count,
			input int unsigned noise_pct);
		logic [15:0] base;
		logic [15:0] lab;
		int unsigned bw;
		int unsigned bh;
		base = 16'($urandom);
		bw   = $urandom_range(1, 4);
		bh   = $urandom_range(1, 4);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				lab = 16'($urandom);
			else
				lab = base ^ 16'(((i % w) / bw + (i / w) / bh) % 3);
			send_pixel(lab, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		end
		pix_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned count;
		int unsigned stop_at;
		int unsigned phase;
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		pix_valid <= 1'b0;
		label     <= '0;
		blue      <= '0;
		green     <= '0;
		red       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry is 640 by 480, so these first-row beats yield nothing.
		send_pixel(16'h0000, 8'h00, 8'h00, 8'h00);
		send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(16'h5A5A, 8'h0F, 8'hF0, 8'hAA);
		pix_valid <= 1'b0;
		wait_drained();

		// Smallest frame with an interior pixel: first its right neighbour
		// differs, then the one below it.
		write_reg(lbo_pkg::REG_WIDTH, 32'd3);
		write_reg(lbo_pkg::REG_HEIGHT, 32'd3);
		for (int i = 0; i < 9; i++)
			send_pixel((i == 5) ? 16'hFFFF : 16'h0000, 8'(i * 31), 8'(255 - i * 17),
				8'(i * 97));
		for (int i = 0; i < 9; i++)
			send_pixel((i == 7) ? 16'h0000 : 16'hFFFF, 8'(255 - i * 29), 8'(i * 13),
				8'(i * 61));
		pix_valid <= 1'b0;
		wait_drained();

		// A height of zero acts as one row: every beat emits only itself.
		write_reg(lbo_pkg::REG_HEIGHT, 32'd0);
		send_pixels(3, 3, 0);
		wait_drained();

		stop_at = pixels_sent + 560;
		phase   = 0;
		while (pixels_sent < stop_at || phase <= 4) begin
			idling = ($urandom_range(0, 3) != 0);
			w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
			h = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			if (phase == 4) begin
				w = 12;
				h = 8;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(lbo_pkg::REG_WIDTH, w);
				write_reg(lbo_pkg::REG_HEIGHT, h);
			end else begin
				write_reg(lbo_pkg::REG_HEIGHT, h);
				write_reg(lbo_pkg::REG_WIDTH, w);
			end
			count = w * h * $urandom_range(1, 2);
			// Some frames are cut short and restarted by the next register write.
			if (phase != 4 && $urandom_range(0, 4) == 0)
				count = $urandom_range(1, count);
			if (phase == 4)
				hold_requests++;
			send_pixels(w, count, ($urandom_range(0, 3) == 0) ? 25 : 0);
			wait_drained();
			phase++;
		end

		// Register values keep only their low bits, and a width of zero acts
		// as a single column.
		idling = 1'b1;
		write_reg(lbo_pkg::REG_WIDTH, 32'hFFFF_F005);
		write_reg(lbo_pkg::REG_HEIGHT, 32'hFFFF_E004);
		send_pixels(5, 20, 10);
		wait_drained();
		write_reg(lbo_pkg::REG_WIDTH, 32'd0);
		write_reg(lbo_pkg::REG_HEIGHT, 32'd3);
		send_pixels(1, 3, 0);
		wait_drained();

		idling = 1'b0;
		write_reg(lbo_pkg::REG_WIDTH, 32'd7);
		write_reg(lbo_pkg::REG_HEIGHT, 32'd5);
		send_pixels(7, 105, 10);

		for (int i = 0; i < 100000 && sb.pending() != 0; i++) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### files.f
src/lbo_pkg.sv
src/lbo_cfg.sv
src/lbo_raster.sv
src/lbo_line_store.sv
src/lbo_overlay.sv
src/label_boundary_overlay.sv
test/label_boundary_overlay_test.sv
